FILE: hdl/ssld_pkg.sv
// Shared types and constants for the servo slew limiter with duty output.
package ssld_pkg;

    // Function code carried on the input func field
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    // Command kinds held in the queue between front and back
    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_SET  = 1'b1
    } ssld_op_t;

    typedef struct packed
    {
        ssld_op_t           op;
        logic [1:0]         idx;
        logic signed [15:0] angle;
    } ssld_cmd_t;

    localparam logic signed [15:0] ANGLE_START = 16'sd100;
    localparam logic signed [15:0] ANGLE_LIMIT = 16'sd180;
    localparam logic [7:0]         ANGLE_MAX   = 8'd180;

    // floor(a * 65535 / 2000) is taken as (a * DUTY_RECIP) >> DUTY_SHIFT,
    // exact for every clamped angle 0..180
    localparam int          DUTY_SHIFT = 20;
    localparam logic [25:0] DUTY_RECIP =
        26'((64'd65535 * (64'd1 << DUTY_SHIFT) + 64'd1999) / 64'd2000);
    localparam logic [12:0] DUTY_OFFSET = 13'((65535 * 500) / 20000);
    localparam logic [12:0] DUTY_MIN    = DUTY_OFFSET;
    localparam logic [12:0] DUTY_MAX    = 13'((180 * 65535) / 2000 + (65535 * 500) / 20000);

endpackage

FILE: hdl/ssld_front.sv
// Front end: accepts transactions, classifies them and queues commands.
module ssld_front #(
    parameter int SERVO_COUNT = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [1:0]          servo_index,
    input  logic signed [15:0]  target_angle,
    output ssld_pkg::ssld_cmd_t cmd,
    output logic                cmd_valid,
    input  logic                cmd_pop
);

    localparam int          DEPTH    = 2;
    localparam logic [4:0]  COUNT_W5 = 5'(SERVO_COUNT);

    ssld_pkg::ssld_cmd_t entry_reg [DEPTH];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                accept;
    logic                keep;
    logic                push;
    logic                pop;
    ssld_pkg::ssld_cmd_t new_cmd;

    always_comb
    begin
        accept = in_valid && !in_stall;
        // drop set-target transactions aimed past the last servo
        if (func == ssld_pkg::FUNC_SET)
        begin
            keep       = (5'(servo_index) < COUNT_W5);
            new_cmd.op = ssld_pkg::OP_SET;
        end
        else
        begin
            keep       = 1'b1;
            new_cmd.op = ssld_pkg::OP_TICK;
        end
        new_cmd.idx   = servo_index;
        new_cmd.angle = target_angle;
        push          = accept && keep;
        pop           = cmd_pop && cmd_valid;
        count_next    = 2'(count_reg + {1'b0, push} - {1'b0, pop});
    end

    assign in_stall  = (count_reg == 2'(DEPTH));
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("command queue over-filled");

endmodule

FILE: hdl/ssld_back.sv
// Back end: servo angle store, one-degree stepping and duty conversion.
module ssld_back #(
    parameter int SERVO_COUNT = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ssld_pkg::ssld_cmd_t cmd,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          servo_num,
    output logic [12:0]         duty_count,
    output logic                last_of_tick
);

    localparam int                IDX_W    = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SERVO_COUNT - 1);

    logic signed [15:0] current_reg [SERVO_COUNT];
    logic signed [15:0] target_reg  [SERVO_COUNT];
    logic [IDX_W-1:0]   servo_reg;
    logic [IDX_W-1:0]   servo_next;
    logic               out_valid_reg;
    logic [1:0]         servo_num_reg;
    logic [12:0]        duty_reg;
    logic               last_reg;

    logic               out_free;
    logic               is_tick;
    logic               is_set;
    logic               step_go;
    logic               at_last;
    logic [IDX_W-1:0]   set_idx;
    logic signed [15:0] cur;
    logic signed [15:0] tgt;
    logic signed [15:0] stepped;
    logic [7:0]         angle_clamped;
    logic [33:0]        product;
    logic [12:0]        duty_next;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        is_tick  = cmd_valid && (cmd.op == ssld_pkg::OP_TICK);
        is_set   = cmd_valid && (cmd.op == ssld_pkg::OP_SET);
        step_go  = is_tick && out_free;
        at_last  = (servo_reg == LAST_IDX);
        cmd_pop  = is_set || (step_go && at_last);
        set_idx  = IDX_W'({{IDX_W{1'b0}}, cmd.idx});

        servo_next = at_last ? '0 : IDX_W'(servo_reg + 1'b1);

        // move one degree toward the target, never past it
        cur = current_reg[servo_reg];
        tgt = target_reg[servo_reg];
        if (cur < tgt)
        begin
            stepped = cur + 16'sd1;
        end
        else if (cur > tgt)
        begin
            stepped = cur - 16'sd1;
        end
        else
        begin
            stepped = cur;
        end

        if (stepped < 16'sd0)
        begin
            angle_clamped = 8'd0;
        end
        else if (stepped > ssld_pkg::ANGLE_LIMIT)
        begin
            angle_clamped = ssld_pkg::ANGLE_MAX;
        end
        else
        begin
            angle_clamped = stepped[7:0];
        end

        product   = 34'(angle_clamped) * 34'(ssld_pkg::DUTY_RECIP);
        duty_next = 13'(product[33:ssld_pkg::DUTY_SHIFT] + 14'(ssld_pkg::DUTY_OFFSET));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SERVO_COUNT; i++)
            begin
                current_reg[i] <= ssld_pkg::ANGLE_START;
                target_reg[i]  <= ssld_pkg::ANGLE_START;
            end
            servo_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (is_set)
            begin
                target_reg[set_idx] <= cmd.angle;
            end
            if (step_go)
            begin
                current_reg[servo_reg] <= stepped;
                servo_reg              <= servo_next;
                out_valid_reg          <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            servo_num_reg <= 2'({2'b00, servo_reg});
            duty_reg      <= duty_next;
            last_reg      <= at_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign servo_num    = servo_num_reg;
    assign duty_count   = duty_reg;
    assign last_of_tick = last_reg;

    a_set_between_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        is_set |-> servo_reg == '0)
        else $error("target write reached the back end in the middle of a tick");

    a_last_servo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> servo_num_reg == 2'(SERVO_COUNT - 1))
        else $error("end-of-tick mark on a servo other than the last");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (duty_reg >= ssld_pkg::DUTY_MIN) && (duty_reg <= ssld_pkg::DUTY_MAX))
        else $error("duty count outside the servo range");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && !at_last |=> servo_reg == $past(servo_reg) + 1'b1)
        else $error("servo counter failed to advance within a tick");

endmodule

FILE: hdl/servo_slew_limiter_duty.sv
// Top level of the multi-servo slew limiter with PWM duty-count results.
// Path: an accepted tick's first result passes the front-end queue, then the back-end output register.
// Throughput: a tick walks the servos one per cycle through the single duty multiplier, while
// the output register is free or being emptied; a set-target transaction only writes a target.
// Reset: every current and target angle returns to 100 degrees, the queue empties and no
// result is pending.
module servo_slew_limiter_duty #(
    parameter int SERVO_COUNT = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [1:0]         servo_index,
    input  logic signed [15:0] target_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         servo_num,
    output logic [12:0]        duty_count,
    output logic               last_of_tick
);

    // Command path between the two halves: a two-entry queue sits in the front end,
    // so incoming transactions are taken while the back end is busy with a tick.
    ssld_pkg::ssld_cmd_t cmd;
    logic                cmd_valid;
    logic                cmd_pop;

    // Front end: classify each transaction as tick or target write, drop target
    // writes for servos that do not exist, and queue the rest in arrival order.
    ssld_front #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .servo_index  (servo_index),
        .target_angle (target_angle),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop)
    );

    // Back end: apply target writes in order, and on a tick walk the servos one
    // per cycle, stepping each angle a degree toward its target, clamping to
    // 0..180 and converting to a duty count held in the output register. The
    // walk only advances when the output register is free or being emptied.
    ssld_back #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .servo_num    (servo_num),
        .duty_count   (duty_count),
        .last_of_tick (last_of_tick)
    );

endmodule
